FILE: hdl/tcw_pkg.sv
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 8;
    localparam int COLS_W      = 8;
    localparam int ROWS_W      = 7;
    localparam int RCOL_W      = 7;
    localparam int RROW_W      = 6;
    localparam int CUR_COL_W   = 8;
    localparam int CUR_ROW_W   = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int MIN_DIM     = 2;

    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 64;

    localparam logic [COLS_W-1:0]  COLS_RESET   = 8'd80;
    localparam logic [ROWS_W-1:0]  ROWS_RESET   = 7'd25;
    localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0a;
    localparam logic [CHAR_W-1:0]  NUL_CHAR     = 8'h00;
    localparam logic [COLOR_W-1:0] BLANK_COLOR  = 8'hf0;

    typedef enum logic [0:0] {
        OP_PUT  = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLS = 1'b0,
        REG_ROWS = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_PUT,
        KIND_NEWLINE,
        KIND_READ
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [CHAR_W-1:0]   ch;
        logic [COLOR_W-1:0]  color;
        logic [RCOL_W-1:0]   rcol;
        logic [RROW_W-1:0]   rrow;
    } t_item;

endpackage

`default_nettype wire

FILE: hdl/tcw_front.sv
// Request intake: classifies each request and holds it in a short queue.
`default_nettype none

module tcw_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_operation,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  wire logic [tcw_pkg::COLOR_W-1:0] i_text_color,
    input  wire logic [tcw_pkg::RCOL_W-1:0]  i_read_col,
    input  wire logic [tcw_pkg::RROW_W-1:0]  i_read_row,
    input  wire logic                        i_busy,
    output logic                             o_q_valid,
    output tcw_pkg::t_item                   o_q_item,
    input  wire logic                        i_q_pop
);
    import tcw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    t_item            w_item;
    logic             w_accept;
    logic             w_pop;

    // Newline and NUL both carry a blank character; a NUL put is drawn as a blank cell.
    always_comb begin
        w_item.color = i_text_color;
        w_item.rcol  = i_read_col;
        w_item.rrow  = i_read_row;
        if (t_op'(i_operation) == OP_READ) begin
            w_item.kind = KIND_READ;
            w_item.ch   = i_char_code;
        end else if (i_char_code == NEWLINE_CHAR) begin
            w_item.kind = KIND_NEWLINE;
            w_item.ch   = BLANK_CHAR;
        end else begin
            w_item.kind = KIND_PUT;
            w_item.ch   = (i_char_code == NUL_CHAR) ? BLANK_CHAR : i_char_code;
        end
    end

    assign o_stall   = (r_count == CNT_W'(QUEUE_DEPTH)) || i_busy;
    assign w_accept  = i_valid && !o_stall;
    assign o_q_valid = (r_count != '0);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_item  = r_q[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_accept) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(r_wptr + 1'b1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(r_rptr + 1'b1);
        end
        if (w_accept && !w_pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (w_pop && !w_accept) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q[r_wptr] <= w_item;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tcw_back.sv
// Execution sequencer: cursor, scroll, cell store and result register.
`default_nettype none

module tcw_back #(
    parameter int MAX_COLS = tcw_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tcw_pkg::DEF_MAX_ROWS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [$clog2(MAX_COLS+1)-1:0] i_nc,
    input  wire logic [$clog2(MAX_ROWS+1)-1:0] i_nr,
    input  wire logic                          i_q_valid,
    input  wire tcw_pkg::t_item                i_q_item,
    output logic                               o_q_pop,
    output logic                               o_busy,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [tcw_pkg::CHAR_W-1:0]         o_read_char,
    output logic [tcw_pkg::COLOR_W-1:0]        o_read_color,
    output logic [tcw_pkg::CUR_COL_W-1:0]      o_cursor_col,
    output logic [tcw_pkg::CUR_ROW_W-1:0]      o_cursor_row,
    output logic                               o_scrolled
);
    import tcw_pkg::*;

    localparam int NC_W   = $clog2(MAX_COLS + 1);
    localparam int PHYS_W = $clog2(MAX_ROWS);
    localparam int ACOL_W = $clog2(MAX_COLS);
    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int AW     = $clog2(DEPTH);
    localparam int MEM_W  = CHAR_W + COLOR_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_NORM,
        S_SBASE,
        S_SCROLL,
        S_PHYS,
        S_ADDR,
        S_ACCESS,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_waddr, n_waddr;
    logic [CUR_COL_W-1:0]  r_cur_col, n_cur_col;
    logic [CUR_ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [PHYS_W-1:0]     r_top, n_top;
    logic                  r_out_valid, n_out_valid;

    t_item                 r_item, n_item;
    logic [PHYS_W-1:0]     r_topm, n_topm;
    logic [NC_W-1:0]       r_cnt, n_cnt;
    logic [PHYS_W-1:0]     r_phys, n_phys;
    logic [ACOL_W-1:0]     r_acol, n_acol;
    logic                  r_hit, n_hit;
    logic [AW-1:0]         r_addr, n_addr;
    logic                  r_scrolled, n_scrolled;
    logic [CHAR_W-1:0]     r_out_char, n_out_char;
    logic [COLOR_W-1:0]    r_out_color, n_out_color;
    logic [CUR_COL_W-1:0]  r_out_col, n_out_col;
    logic [CUR_ROW_W-1:0]  r_out_row, n_out_row;
    logic                  r_out_scr, n_out_scr;

    logic [MEM_W-1:0]      r_mem [DEPTH];
    logic [MEM_W-1:0]      r_rdata;

    logic                  w_out_free;
    logic                  w_pop;
    logic                  w_is_read;
    logic [CUR_COL_W-1:0]  w_col1;
    logic [CUR_ROW_W-1:0]  w_row1;
    logic [PHYS_W-1:0]     w_top_next;
    logic [CUR_COL_W-1:0]  w_sel_col;
    logic [CUR_ROW_W-1:0]  w_sel_row;
    logic                  w_sel_hit;
    logic [PHYS_W:0]       w_psum;
    logic [PHYS_W-1:0]     w_phys;
    logic                  w_we;
    logic [AW-1:0]         w_wa;
    logic [MEM_W-1:0]      w_wd;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_is_read  = (r_item.kind == KIND_READ);

    // Newline takes priority over a wrap at the row width.
    always_comb begin
        w_col1 = r_cur_col;
        w_row1 = r_cur_row;
        if (r_item.kind == KIND_NEWLINE) begin
            w_col1 = '0;
            w_row1 = CUR_ROW_W'(r_cur_row + 1'b1);
        end else if (32'(r_cur_col) >= 32'(i_nc)) begin
            w_col1 = CUR_COL_W'(1);
            w_row1 = CUR_ROW_W'(r_cur_row + 1'b1);
        end
    end

    assign w_top_next = (32'(r_topm) + 1 >= 32'(i_nr)) ? '0 : PHYS_W'(r_topm + 1'b1);

    // A cell is addressed through the reduced window base; the sum wraps at most once.
    always_comb begin
        if (w_is_read) begin
            w_sel_col = CUR_COL_W'(r_item.rcol);
            w_sel_row = CUR_ROW_W'(r_item.rrow);
            w_sel_hit = (32'(r_item.rcol) < 32'(i_nc)) && (32'(r_item.rrow) < 32'(i_nr));
        end else begin
            w_sel_col = r_cur_col;
            w_sel_row = r_cur_row;
            w_sel_hit = (r_cur_col != '0) && (32'(r_cur_col) < 32'(i_nc))
                     && (r_cur_row != '0) && (32'(r_cur_row) < 32'(i_nr));
        end
        w_psum = {1'b0, r_topm} + (PHYS_W+1)'(w_sel_row);
        if (32'(w_psum) >= 32'(i_nr)) begin
            w_phys = PHYS_W'(w_psum - (PHYS_W+1)'(i_nr));
        end else begin
            w_phys = PHYS_W'(w_psum);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_waddr     = r_waddr;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_top       = r_top;
        n_out_valid = r_out_valid;
        n_item      = r_item;
        n_topm      = r_topm;
        n_cnt       = r_cnt;
        n_phys      = r_phys;
        n_acol      = r_acol;
        n_hit       = r_hit;
        n_addr      = r_addr;
        n_scrolled  = r_scrolled;
        n_out_char  = r_out_char;
        n_out_color = r_out_color;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_scr   = r_out_scr;
        w_pop       = 1'b0;
        w_we        = 1'b0;
        w_wa        = r_waddr;
        w_wd        = {BLANK_CHAR, BLANK_COLOR};

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                n_waddr = AW'(r_waddr + 1'b1);
                if (r_waddr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                w_pop = i_q_valid;
            end
            S_NORM: begin
                if (32'(r_topm) >= 32'(i_nr)) begin
                    // The base is left over from a larger window; reduce it a step at a time.
                    n_topm = PHYS_W'(32'(r_topm) - 32'(i_nr));
                end else if (w_is_read) begin
                    n_state = S_PHYS;
                end else begin
                    n_cur_col = w_col1;
                    n_cur_row = w_row1;
                    n_state   = S_PHYS;
                    if (32'(w_row1) >= 32'(i_nr)) begin
                        n_cur_row  = CUR_ROW_W'(i_nr - 1'b1);
                        n_scrolled = 1'b1;
                        n_state    = S_SBASE;
                    end
                end
            end
            S_SBASE: begin
                n_waddr = AW'(32'(r_topm) * 32'(i_nc));
                n_cnt   = '0;
                n_state = S_SCROLL;
            end
            S_SCROLL: begin
                w_we    = 1'b1;
                n_waddr = AW'(r_waddr + 1'b1);
                n_cnt   = NC_W'(r_cnt + 1'b1);
                if (32'(r_cnt) + 1 >= 32'(i_nc)) begin
                    n_top   = w_top_next;
                    n_topm  = w_top_next;
                    n_state = S_PHYS;
                end
            end
            S_PHYS: begin
                n_phys  = w_phys;
                n_acol  = ACOL_W'(w_sel_col);
                n_hit   = w_sel_hit;
                n_state = S_ADDR;
            end
            S_ADDR: begin
                n_addr  = AW'(32'(r_phys) * 32'(i_nc) + 32'(r_acol));
                n_state = S_ACCESS;
            end
            S_ACCESS: begin
                if (!w_is_read) begin
                    w_we      = r_hit;
                    w_wa      = r_addr;
                    w_wd      = {r_item.ch, r_item.color};
                    n_cur_col = CUR_COL_W'(r_cur_col + 1'b1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (w_is_read && r_hit) begin
                        n_out_char  = r_rdata[MEM_W-1:COLOR_W];
                        n_out_color = r_rdata[COLOR_W-1:0];
                    end else begin
                        n_out_char  = '0;
                        n_out_color = '0;
                    end
                    n_out_col = r_cur_col;
                    n_out_row = r_cur_row;
                    n_out_scr = r_scrolled;
                    w_pop     = i_q_valid;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_pop) begin
            n_item     = i_q_item;
            n_topm     = r_top;
            n_scrolled = 1'b0;
            n_state    = S_NORM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_waddr     <= '0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_waddr     <= n_waddr;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
        end
        r_item      <= n_item;
        r_topm      <= n_topm;
        r_cnt       <= n_cnt;
        r_phys      <= n_phys;
        r_acol      <= n_acol;
        r_hit       <= n_hit;
        r_addr      <= n_addr;
        r_scrolled  <= n_scrolled;
        r_out_char  <= n_out_char;
        r_out_color <= n_out_color;
        r_out_col   <= n_out_col;
        r_out_row   <= n_out_row;
        r_out_scr   <= n_out_scr;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[r_addr];
    end

    assign o_q_pop      = w_pop;
    assign o_busy       = (r_state == S_CLEAR);
    assign o_valid      = r_out_valid;
    assign o_read_char  = r_out_char;
    assign o_read_color = r_out_color;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_scrolled   = r_out_scr;

endmodule

`default_nettype wire

FILE: hdl/text_console_writer_unit.sv
// Text console writer: a character window with cursor, wrap and scroll.
//
// Requests enter on i_valid/o_stall and carry a put (one character and its
// color at the cursor) or a read (one cell). Each request gives one result on
// o_valid/i_stall with the read cell, the cursor after the request and a
// scroll flag. Geometry is set through the write port (i_cfg_we, i_cfg_index,
// i_cfg_data); the user must write it only while no request is in flight, as
// the block itself does not enforce this. In the execution sequencer a request
// passes through cursor update, window row, address multiply, store access and
// result; a scroll blanks one row of the store after the cursor update. After
// the row count is lowered, the window base is reduced by subtraction.
// After reset the store is blanked, one cell a cycle, over its MAX_COLS *
// MAX_ROWS cells (8192 at the defaults); o_stall stays high during that pass.
// A two-entry request queue and the result register let the sides stall
// independently: while the receiver stalls, a finished result holds and up to
// three more requests are still taken, one into the sequencer and two queued.
`default_nettype none

module text_console_writer_unit #(
    parameter int MAX_COLS = tcw_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tcw_pkg::DEF_MAX_ROWS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_operation,
    input  wire logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  wire logic [tcw_pkg::COLOR_W-1:0]    i_text_color,
    input  wire logic [tcw_pkg::RCOL_W-1:0]     i_read_col,
    input  wire logic [tcw_pkg::RROW_W-1:0]     i_read_row,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [tcw_pkg::CHAR_W-1:0]          o_read_char,
    output logic [tcw_pkg::COLOR_W-1:0]         o_read_color,
    output logic [tcw_pkg::CUR_COL_W-1:0]       o_cursor_col,
    output logic [tcw_pkg::CUR_ROW_W-1:0]       o_cursor_row,
    output logic                                o_scrolled
);
    import tcw_pkg::*;

    localparam int NC_W = $clog2(MAX_COLS + 1);
    localparam int NR_W = $clog2(MAX_ROWS + 1);

    logic [COLS_W-1:0] r_cols;
    logic [ROWS_W-1:0] r_rows;
    logic [NC_W-1:0]   w_nc;
    logic [NR_W-1:0]   w_nr;
    logic              w_busy;
    logic              w_q_valid;
    logic              w_q_pop;
    t_item             w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_COLS: begin
                    r_cols <= i_cfg_data[COLS_W-1:0];
                end
                REG_ROWS: begin
                    r_rows <= i_cfg_data[ROWS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Out-of-range geometry is clamped to the supported window.
    always_comb begin
        if (32'(r_cols) > MAX_COLS) begin
            w_nc = NC_W'(MAX_COLS);
        end else if (32'(r_cols) < MIN_DIM) begin
            w_nc = NC_W'(MIN_DIM);
        end else begin
            w_nc = NC_W'(r_cols);
        end
        if (32'(r_rows) > MAX_ROWS) begin
            w_nr = NR_W'(MAX_ROWS);
        end else if (32'(r_rows) < MIN_DIM) begin
            w_nr = NR_W'(MIN_DIM);
        end else begin
            w_nr = NR_W'(r_rows);
        end
    end

    tcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_char_code  (i_char_code),
        .i_text_color (i_text_color),
        .i_read_col   (i_read_col),
        .i_read_row   (i_read_row),
        .i_busy       (w_busy),
        .o_q_valid    (w_q_valid),
        .o_q_item     (w_q_item),
        .i_q_pop      (w_q_pop)
    );

    tcw_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nc         (w_nc),
        .i_nr         (w_nr),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_q_item),
        .o_q_pop      (w_q_pop),
        .o_busy       (w_busy),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_char  (o_read_char),
        .o_read_color (o_read_color),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_scrolled   (o_scrolled)
    );

endmodule

`default_nettype wire

FILE: sim/text_console_writer_unit_tb.sv
// Self-checking testbench for the text console writer: directed table plus random phases.
`timescale 1ns / 100ps

module text_console_writer_unit_tb;
    import tcw_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_COLS * DEF_MAX_ROWS;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int PHASES = 16;
    localparam int PHASE_REQUESTS = 125;

    typedef struct packed {
        t_op                op;
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] color;
        logic [RCOL_W-1:0]  rcol;
        logic [RROW_W-1:0]  rrow;
    } t_console_request;

    typedef struct packed {
        logic [CHAR_W-1:0]    rd_char;
        logic [COLOR_W-1:0]   rd_color;
        logic [CUR_COL_W-1:0] col;
        logic [CUR_ROW_W-1:0] row;
        logic                 scrolled;
    } t_cell_cursor;

    typedef struct packed {
        logic             is_cfg;
        t_reg_idx         reg_idx;
        logic [7:0]       value;
        t_console_request req;
        logic             typed;
        t_cell_cursor     want;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_operation = 1'b0;
    logic [CHAR_W-1:0]     i_char_code = '0;
    logic [COLOR_W-1:0]    i_text_color = '0;
    logic [RCOL_W-1:0]     i_read_col = '0;
    logic [RROW_W-1:0]     i_read_row = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b1;
    logic [CHAR_W-1:0]     o_read_char;
    logic [COLOR_W-1:0]    o_read_color;
    logic [CUR_COL_W-1:0]  o_cursor_col;
    logic [CUR_ROW_W-1:0]  o_cursor_row;
    logic                  o_scrolled;

    text_console_writer_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_char_code  (i_char_code),
        .i_text_color (i_text_color),
        .i_read_col   (i_read_col),
        .i_read_row   (i_read_row),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_char  (o_read_char),
        .o_read_color (o_read_color),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_scrolled   (o_scrolled)
    );

    // Shadow copy of the window, the cursor and the geometry registers.
    logic [CHAR_W-1:0]    screen_chars [STORE_DEPTH];
    logic [COLOR_W-1:0]   screen_colors [STORE_DEPTH];
    logic [CUR_COL_W-1:0] cursor_col = '0;
    logic [CUR_ROW_W-1:0] cursor_row = '0;
    int unsigned          top_base = 0;
    logic [COLS_W-1:0]    cols_reg = COLS_RESET;
    logic [ROWS_W-1:0]    rows_reg = ROWS_RESET;

    t_cell_cursor cell_cursor_replies [$];
    t_plan_row    plan_rows [$];
    int unsigned  in_idle_pct = 31;
    int unsigned  out_idle_pct = 31;
    int           mismatches = 0;
    int           cycle_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < out_idle_pct);
    end

    function automatic int unsigned eff_cols();
        if (cols_reg < MIN_DIM) return MIN_DIM;
        if (cols_reg > DEF_MAX_COLS) return DEF_MAX_COLS;
        return cols_reg;
    endfunction

    function automatic int unsigned eff_rows();
        if (rows_reg < MIN_DIM) return MIN_DIM;
        if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
        return rows_reg;
    endfunction

    function automatic int unsigned cell_index(int unsigned col, int unsigned row,
                                               int unsigned nc, int unsigned nr);
        return (((top_base + row) % nr) * nc + col) % STORE_DEPTH;
    endfunction

    // Applies one request to the shadow window and returns the reply it should produce.
    function automatic t_cell_cursor run_console_request(t_console_request req);
        int unsigned       nc;
        int unsigned       nr;
        int unsigned       phys;
        int unsigned       a;
        logic [CHAR_W-1:0] ch;
        t_cell_cursor      r;
        nc = eff_cols();
        nr = eff_rows();
        r = '0;
        if (req.op == OP_READ) begin
            if (req.rcol < nc && req.rrow < nr) begin
                a = cell_index(req.rcol, req.rrow, nc, nr);
                r.rd_char = screen_chars[a];
                r.rd_color = screen_colors[a];
            end
        end else begin
            ch = req.ch;
            if (ch == NEWLINE_CHAR) begin
                cursor_row = cursor_row + 1'b1;
                cursor_col = '0;
                ch = BLANK_CHAR;
            end else if (cursor_col >= nc) begin
                cursor_col = 8'd1;
                cursor_row = cursor_row + 1'b1;
            end
            // A single scroll is enough even when the cursor sits far below a shrunk window.
            if (cursor_row >= nr) begin
                phys = top_base % nr;
                for (int unsigned c = 0; c < nc; c++) begin
                    screen_chars[phys * nc + c] = BLANK_CHAR;
                    screen_colors[phys * nc + c] = BLANK_COLOR;
                end
                top_base = (phys + 1) % nr;
                cursor_row = CUR_ROW_W'(nr - 1);
                r.scrolled = 1'b1;
            end
            if (ch == NUL_CHAR) ch = BLANK_CHAR;
            if (cursor_col > 0 && cursor_col < nc && cursor_row > 0 && cursor_row < nr) begin
                a = cell_index(cursor_col, cursor_row, nc, nr);
                screen_chars[a] = ch;
                screen_colors[a] = req.color;
            end
            cursor_col = cursor_col + 1'b1;
        end
        r.col = cursor_col;
        r.row = cursor_row;
        return r;
    endfunction

    function automatic t_console_request random_request(int unsigned newline_pct);
        t_console_request req;
        int unsigned      nc;
        int unsigned      nr;
        nc = eff_cols();
        nr = eff_rows();
        req.op = ($urandom_range(99) < 45) ? OP_READ : OP_PUT;
        req.color = CHAR_W'($urandom_range(255));
        req.rcol = RCOL_W'($urandom_range(127));
        req.rrow = RROW_W'($urandom_range(63));
        if (req.op == OP_READ && $urandom_range(99) < 85) begin
            req.rcol = RCOL_W'($urandom_range(nc - 1));
            req.rrow = RROW_W'($urandom_range(nr - 1));
        end
        if ($urandom_range(99) < newline_pct) req.ch = NEWLINE_CHAR;
        else if ($urandom_range(99) < 5) req.ch = NUL_CHAR;
        else req.ch = CHAR_W'($urandom_range(255));
        return req;
    endfunction

    function automatic void plan_register(t_reg_idx idx, logic [7:0] value);
        t_plan_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.value = value;
        plan_rows.push_back(row);
    endfunction

    function automatic void plan_request(t_op op, logic [7:0] ch, logic [7:0] color,
                                         logic [6:0] rcol, logic [5:0] rrow,
                                         logic typed = 1'b0, t_cell_cursor want = '0);
        t_plan_row row;
        row = '0;
        row.req = '{op, ch, color, rcol, rrow};
        row.typed = typed;
        row.want = want;
        plan_rows.push_back(row);
    endfunction

    task automatic issue_request(t_console_request req, logic typed, t_cell_cursor want);
        t_cell_cursor predicted;
        while ($urandom_range(99) < in_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= req.op;
        i_char_code <= req.ch;
        i_text_color <= req.color;
        i_read_col <= req.rcol;
        i_read_row <= req.rrow;
        do @(posedge i_clk); while (o_stall);
        predicted = run_console_request(req);
        cell_cursor_replies.push_back(typed ? want : predicted);
    endtask

    // Geometry changes only once every outstanding reply has been seen.
    task automatic write_register(t_reg_idx idx, logic [7:0] value);
        i_valid <= 1'b0;
        while (cell_cursor_replies.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_COLS) cols_reg = value;
        else rows_reg = value[ROWS_W-1:0];
    endtask

    always @(posedge i_clk) begin
        t_cell_cursor want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (cell_cursor_replies.size() == 0) begin
                $error("result with no request outstanding");
                mismatches++;
            end else begin
                want = cell_cursor_replies.pop_front();
                if (o_read_char !== want.rd_char) begin
                    $error("read_char: expected %0h, got %0h", want.rd_char, o_read_char);
                    mismatches++;
                end
                if (o_read_color !== want.rd_color) begin
                    $error("read_color: expected %0h, got %0h", want.rd_color, o_read_color);
                    mismatches++;
                end
                if (o_cursor_col !== want.col) begin
                    $error("cursor_col: expected %0d, got %0d", want.col, o_cursor_col);
                    mismatches++;
                end
                if (o_cursor_row !== want.row) begin
                    $error("cursor_row: expected %0d, got %0d", want.row, o_cursor_row);
                    mismatches++;
                end
                if (o_scrolled !== want.scrolled) begin
                    $error("scrolled: expected %0d, got %0d", want.scrolled, o_scrolled);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        logic [7:0]  wcols;
        logic [7:0]  wrows;
        int unsigned nl_pct;
        int unsigned pick;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            screen_chars[i] = BLANK_CHAR;
            screen_colors[i] = BLANK_COLOR;
        end

        // Reset geometry is 80 x 25 with the cursor at the origin.
        plan_request(OP_READ, 8'h00, 8'h00, 7'd0, 6'd0, 1'b1,
                     '{BLANK_CHAR, BLANK_COLOR, 8'd0, 7'd0, 1'b0});
        // Column 0 and row 0 are never drawn, only the cursor moves.
        plan_request(OP_PUT, 8'h41, 8'h1f, 7'd0, 6'd0, 1'b1, '{8'h00, 8'h00, 8'd1, 7'd0, 1'b0});
        plan_request(OP_PUT, NEWLINE_CHAR, 8'h55, 7'd127, 6'd63, 1'b1,
                     '{8'h00, 8'h00, 8'd1, 7'd1, 1'b0});
        plan_request(OP_PUT, 8'hff, 8'hff, 7'd0, 6'd0, 1'b1, '{8'h00, 8'h00, 8'd2, 7'd1, 1'b0});
        plan_request(OP_PUT, NUL_CHAR, 8'h00, 7'd0, 6'd0, 1'b1, '{8'h00, 8'h00, 8'd3, 7'd1, 1'b0});
        plan_request(OP_READ, 8'h00, 8'h00, 7'd1, 6'd1, 1'b1, '{8'hff, 8'hff, 8'd3, 7'd1, 1'b0});
        plan_request(OP_READ, 8'hff, 8'hff, 7'd2, 6'd1, 1'b1,
                     '{BLANK_CHAR, 8'h00, 8'd3, 7'd1, 1'b0});
        // Reads outside the window return an empty cell; the last cell inside holds a blank.
        plan_request(OP_READ, 8'h00, 8'h00, 7'd127, 6'd63, 1'b1,
                     '{8'h00, 8'h00, 8'd3, 7'd1, 1'b0});
        plan_request(OP_READ, 8'h00, 8'h00, 7'd79, 6'd24, 1'b1,
                     '{BLANK_CHAR, BLANK_COLOR, 8'd3, 7'd1, 1'b0});
        plan_request(OP_READ, 8'h00, 8'h00, 7'd80, 6'd0, 1'b1, '{8'h00, 8'h00, 8'd3, 7'd1, 1'b0});
        plan_request(OP_READ, 8'h00, 8'h00, 7'd0, 6'd25, 1'b1, '{8'h00, 8'h00, 8'd3, 7'd1, 1'b0});
        // Smallest window: a wrap that also scrolls, then a newline that scrolls.
        plan_register(REG_COLS, 8'd2);
        plan_register(REG_ROWS, 8'd2);
        plan_request(OP_PUT, 8'h42, 8'h0f, 7'd0, 6'd0, 1'b1, '{8'h00, 8'h00, 8'd2, 7'd1, 1'b1});
        plan_request(OP_READ, 8'h00, 8'h00, 7'd1, 6'd1, 1'b1, '{8'h42, 8'h0f, 8'd2, 7'd1, 1'b0});
        plan_request(OP_PUT, NEWLINE_CHAR, 8'h21, 7'd0, 6'd0, 1'b1,
                     '{8'h00, 8'h00, 8'd1, 7'd1, 1'b1});
        plan_request(OP_READ, 8'h00, 8'h00, 7'd1, 6'd1);
        // Out-of-range geometry saturates to the legal limits.
        plan_register(REG_COLS, 8'd0);
        plan_register(REG_ROWS, 8'd1);
        plan_request(OP_PUT, 8'h80, 8'h80, 7'd0, 6'd0);
        plan_register(REG_COLS, 8'd255);
        plan_register(REG_ROWS, 8'd127);
        plan_request(OP_PUT, 8'h7f, 8'h01, 7'd0, 6'd0);
        plan_request(OP_READ, 8'h00, 8'h00, 7'd127, 6'd63);
        plan_request(OP_READ, 8'h00, 8'h00, 7'd2, 6'd1);
        plan_register(REG_COLS, 8'd128);
        plan_register(REG_ROWS, 8'd64);
        plan_request(OP_PUT, NEWLINE_CHAR, 8'haa, 7'd0, 6'd0);
        plan_request(OP_READ, 8'h00, 8'h00, 7'd0, 6'd0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan_rows[i]) begin
            if (plan_rows[i].is_cfg) write_register(plan_rows[i].reg_idx, plan_rows[i].value);
            else issue_request(plan_rows[i].req, plan_rows[i].typed, plan_rows[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            // Every fourth phase fills a tall window so that the next one, if shorter,
            // starts with the cursor well below its last row.
            if (phase % 4 == 0) begin
                wcols = 8'($urandom_range(2, 12));
                wrows = 8'd64;
                nl_pct = 60;
            end else begin
                pick = $urandom_range(9);
                case (pick)
                    0: begin
                        wcols = 8'($urandom_range(255));
                        wrows = 8'($urandom_range(127));
                    end
                    1: begin
                        wcols = 8'd128;
                        wrows = 8'd64;
                    end
                    2: begin
                        wcols = 8'd2;
                        wrows = 8'd2;
                    end
                    default: begin
                        wcols = 8'($urandom_range(2, 16));
                        wrows = 8'($urandom_range(2, 8));
                    end
                endcase
                nl_pct = $urandom_range(40);
            end
            write_register(REG_COLS, wcols);
            write_register(REG_ROWS, wrows);
            in_idle_pct = (phase == 6) ? 0 : 31;
            out_idle_pct = (phase == 6) ? 0 : 31;
            repeat (PHASE_REQUESTS) issue_request(random_request(nl_pct), 1'b0, '0);
        end

        i_valid <= 1'b0;
        while (cell_cursor_replies.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
